// ===== src/slmr_pkg.sv =====
// Shared types and constants of the scrolling LED matrix remapper.
`timescale 1ns / 1ps
`default_nettype none
package slmr_pkg;

   localparam logic [1:0] OP_PIXEL = 2'd0;
   localparam logic [1:0] OP_MAP = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;
   localparam logic [1:0] OP_RENDER = 2'd3;

   localparam logic [1:0] REG_WIDTH = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_SPEED_X = 2'd2;
   localparam logic [1:0] REG_SPEED_Y = 2'd3;

   localparam int SIZE_W = 13;
   localparam int SPEED_W = 10;
   localparam int OFFSET_W = 12;
   localparam int ELAPSED_W = 11;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 11'd2047;
   localparam logic [20:0] STEP_PERIOD_BASE = 21'd1000;

   typedef struct packed {
      logic [1:0] opcode;
      logic [11:0] address;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [8:0] led_position;
   } req_type;

   typedef struct packed {
      logic [8:0] led_index;
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic refresh_due;
      logic size_error;
   } rsp_type;

   typedef struct packed {
      req_type req;
      logic pix_ok;
      logic map_ok;
   } entry_type;

   typedef struct packed {
      logic valid;
      logic [1:0] index;
      logic [SIZE_W-1:0] data;
   } csr_type;

endpackage
`default_nettype wire

// ===== src/scrolling_led_matrix_remapper.sv =====
// Top level of the scrolling LED matrix remapper.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted word gives exactly one result word, shown for one cycle with
// rsp_valid high; the receiver cannot stall it. A tick runs one 13-step divide
// for the wrap of each axis that moves and has a nonzero size, and a render
// makes two passes through the shared one-bit-per-cycle divider. A render
// outside the matrix or with a bad image size returns without dividing. A
// two-word queue lets start be taken while the previous word is still at work;
// busy is high only while it is full. Configuration writes are always ready
// and must be issued while the block is idle.
module scrolling_led_matrix_remapper #(
   parameter int MATRIX_ROWS = 16,
   parameter int MATRIX_COLUMNS = 32,
   parameter int IMAGE_PIXELS = 4096
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire slmr_pkg::req_type req_data,
   output logic rsp_valid,
   output slmr_pkg::rsp_type rsp_data,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [1:0] csr_index,
   input wire logic [slmr_pkg::SIZE_W-1:0] csr_data
);
   import slmr_pkg::*;

   localparam int LOGICAL_LEDS = MATRIX_ROWS * MATRIX_COLUMNS;

   logic q_valid;
   logic pop;
   entry_type q_item;
   csr_type csr;

   assign csr_ready = 1'b1;
   assign csr = '{valid: csr_valid, index: csr_index, data: csr_data};

   slmr_front #(.IMAGE_PIXELS(IMAGE_PIXELS), .LOGICAL_LEDS(LOGICAL_LEDS)) u_front (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_data(req_data),
      .busy(busy),
      .pop(pop),
      .q_valid(q_valid),
      .q_item(q_item)
   );

   slmr_back #(
      .MATRIX_COLUMNS(MATRIX_COLUMNS),
      .IMAGE_PIXELS(IMAGE_PIXELS),
      .LOGICAL_LEDS(LOGICAL_LEDS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_item(q_item),
      .pop(pop),
      .csr(csr),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_tick_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.refresh_due |-> rsp_data.led_index == '0
         && rsp_data.red_out == '0 && rsp_data.green_out == '0
         && rsp_data.blue_out == '0)
      else $error("tick result carries pixel data");

   a_error_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.size_error |-> rsp_data.red_out == '0
         && rsp_data.green_out == '0 && rsp_data.blue_out == '0)
      else $error("colour returned with a bad image size");
endmodule
`default_nettype wire

// ===== src/slmr_ram.sv =====
// Generic single-port-write RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module slmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input wire logic clock,
   input wire logic we,
   input wire logic [AW-1:0] waddr,
   input wire logic [WIDTH-1:0] wdata,
   input wire logic [AW-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== src/slmr_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module slmr_div (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [slmr_pkg::SIZE_W-1:0] dividend,
   input wire logic [slmr_pkg::SIZE_W-1:0] divisor,
   output logic done,
   output logic [slmr_pkg::SIZE_W-1:0] remainder
);
   import slmr_pkg::*;

   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W-1:0] quo_ff, quo_in;
   logic [SIZE_W-1:0] dvs_ff;
   logic [3:0] cnt_ff;
   logic run_ff;
   logic done_ff;
   logic [SIZE_W:0] trial;

   always_comb begin
      trial = {rem_ff, quo_ff[SIZE_W-1]};
      quo_in = {quo_ff[SIZE_W-2:0], 1'b0};
      rem_in = trial[SIZE_W-1:0];
      if (trial >= {1'b0, dvs_ff}) begin
         rem_in = SIZE_W'(trial - {1'b0, dvs_ff});
         quo_in[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= 4'(SIZE_W);
            rem_ff <= '0;
            quo_ff <= dividend;
            dvs_ff <= divisor;
         end else if (run_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff - 4'd1;
            if (cnt_ff == 4'd1) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

// ===== src/slmr_front.sv =====
// Command front end: accepts words, checks address ranges and queues them.
`timescale 1ns / 1ps
`default_nettype none
module slmr_front #(
   parameter int IMAGE_PIXELS = 4096,
   parameter int LOGICAL_LEDS = 512
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire slmr_pkg::req_type req_data,
   output logic busy,
   input wire logic pop,
   output logic q_valid,
   output slmr_pkg::entry_type q_item
);
   import slmr_pkg::*;

   entry_type slot_ff [2];
   logic wr_ptr_ff;
   logic rd_ptr_ff;
   logic [1:0] count_ff;
   logic push;
   entry_type incoming;

   always_comb begin
      incoming.req = req_data;
      incoming.pix_ok = 32'(req_data.address) < 32'(IMAGE_PIXELS);
      incoming.map_ok = 32'(req_data.address) < 32'(LOGICAL_LEDS);
   end

   assign busy = (count_ff == 2'd2);
   assign push = start && !busy;
   assign q_valid = (count_ff != 2'd0);
   assign q_item = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) begin
            slot_ff[wr_ptr_ff] <= incoming;
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop && q_valid) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop && q_valid);
      end
   end
endmodule
`default_nettype wire

// ===== src/slmr_back.sv =====
// Command back end: stores, timers, scroll state and the render sequence.
`timescale 1ns / 1ps
`default_nettype none
module slmr_back #(
   parameter int MATRIX_COLUMNS = 32,
   parameter int IMAGE_PIXELS = 4096,
   parameter int LOGICAL_LEDS = 512
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic q_valid,
   input wire slmr_pkg::entry_type q_item,
   output logic pop,
   input wire slmr_pkg::csr_type csr,
   output logic rsp_valid,
   output slmr_pkg::rsp_type rsp_data
);
   import slmr_pkg::*;

   localparam int PAW = (IMAGE_PIXELS > 1) ? $clog2(IMAGE_PIXELS) : 1;
   localparam int MAW = (LOGICAL_LEDS > 1) ? $clog2(LOGICAL_LEDS) : 1;
   localparam int PWW = (PAW > 12) ? PAW : 12;
   localparam int MWW = (MAW > 12) ? MAW : 12;
   localparam int RECIP_SHIFT = 18;
   localparam logic [18:0] RECIP =
      19'(((1 << RECIP_SHIFT) + MATRIX_COLUMNS - 1) / MATRIX_COLUMNS);

   typedef enum logic [3:0] {
      S_IDLE, S_WRITE, S_TX, S_TX_WAIT, S_TY, S_TY_WAIT, S_TDONE,
      S_R0, S_R_XY_WAIT, S_R_GX_WAIT, S_R_GY_WAIT, S_R_IDX, S_R_READ, S_R_DATA
   } state_type;

   state_type state_ff;
   entry_type cmd_ff;
   logic [SIZE_W-1:0] width_ff, height_ff;
   logic [SPEED_W-1:0] speed_x_ff, speed_y_ff;
   logic [OFFSET_W-1:0] offset_x_ff, offset_y_ff;
   logic [ELAPSED_W-1:0] elapsed_x_ff, elapsed_y_ff;
   logic pending_ff, moved_ff, bad_ff;
   logic [8:0] led_ff;
   logic [5:0] y_ff;
   logic [SIZE_W-1:0] gx_ff, gy_ff;
   logic [2*SIZE_W-1:0] idx_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic div_start_ff;
   logic [SIZE_W-1:0] div_a_ff, div_b_ff;
   logic div_done;
   logic [SIZE_W-1:0] div_rem;

   logic [ELAPSED_W-1:0] ex_in, ey_in;
   logic move_x, move_y;
   logic [30:0] y_prod;
   logic [5:0] y_calc;
   logic [SIZE_W-1:0] x_calc;
   logic [PWW-1:0] pix_waddr_wide;
   logic [MWW-1:0] map_addr_wide;
   logic pix_we, map_we;
   logic [23:0] pix_rdata;
   logic [8:0] map_rdata;

   function automatic rsp_type pack_rsp(input logic [8:0] led, input logic [23:0] rgb,
                                        input logic due, input logic err);
      return {led, rgb, due, err};
   endfunction

   always_comb begin
      ex_in = (elapsed_x_ff < ELAPSED_MAX) ? elapsed_x_ff + 11'd1 : elapsed_x_ff;
      ey_in = (elapsed_y_ff < ELAPSED_MAX) ? elapsed_y_ff + 11'd1 : elapsed_y_ff;
      move_x = (speed_x_ff != '0) && (21'(ex_in) * 21'(speed_x_ff) > STEP_PERIOD_BASE);
      move_y = (speed_y_ff != '0) && (21'(ey_in) * 21'(speed_y_ff) > STEP_PERIOD_BASE);
      y_prod = 31'(cmd_ff.req.address) * 31'(RECIP);
      y_calc = y_prod[RECIP_SHIFT+5:RECIP_SHIFT];
      x_calc = 13'(cmd_ff.req.address) - 13'(y_ff) * 13'(MATRIX_COLUMNS);
   end

   assign pop = (state_ff == S_IDLE) && q_valid;
   assign pix_waddr_wide = PWW'(cmd_ff.req.address);
   assign map_addr_wide = MWW'(cmd_ff.req.address);
   assign pix_we = (state_ff == S_WRITE) && (cmd_ff.req.opcode == OP_PIXEL) && cmd_ff.pix_ok;
   assign map_we = (state_ff == S_WRITE) && (cmd_ff.req.opcode == OP_MAP) && cmd_ff.map_ok;

   slmr_ram #(.WIDTH(24), .DEPTH(IMAGE_PIXELS)) u_pixels (
      .clock(clock),
      .we(pix_we),
      .waddr(pix_waddr_wide[PAW-1:0]),
      .wdata({cmd_ff.req.red_in, cmd_ff.req.green_in, cmd_ff.req.blue_in}),
      .raddr(idx_ff[PAW-1:0]),
      .rdata(pix_rdata)
   );

   slmr_ram #(.WIDTH(9), .DEPTH(LOGICAL_LEDS)) u_map (
      .clock(clock),
      .we(map_we),
      .waddr(map_addr_wide[MAW-1:0]),
      .wdata(cmd_ff.req.led_position),
      .raddr(map_addr_wide[MAW-1:0]),
      .rdata(map_rdata)
   );

   slmr_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start_ff),
      .dividend(div_a_ff),
      .divisor(div_b_ff),
      .done(div_done),
      .remainder(div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         width_ff <= 13'd2;
         height_ff <= 13'd2;
         speed_x_ff <= '0;
         speed_y_ff <= '0;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         elapsed_x_ff <= '0;
         elapsed_y_ff <= '0;
         pending_ff <= 1'b1;
         moved_ff <= 1'b0;
         bad_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         bad_ff <= (width_ff == '0) || (height_ff == '0)
                   || (32'(width_ff) * 32'(height_ff) > 32'(IMAGE_PIXELS));
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  cmd_ff <= q_item;
                  moved_ff <= 1'b0;
                  unique case (q_item.req.opcode)
                     OP_PIXEL, OP_MAP: state_ff <= S_WRITE;
                     OP_TICK: state_ff <= S_TX;
                     default: state_ff <= S_R0;
                  endcase
               end
            end
            S_WRITE: begin
               if (pix_we || map_we) begin
                  pending_ff <= 1'b1;
               end
               rsp_ff <= pack_rsp(9'd0, 24'd0, 1'b0, bad_ff);
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_TX: begin
               state_ff <= S_TY;
               if (move_x) begin
                  elapsed_x_ff <= '0;
                  moved_ff <= 1'b1;
                  if (width_ff == '0) begin
                     offset_x_ff <= '0;
                  end else begin
                     div_a_ff <= 13'(offset_x_ff) + 13'd1;
                     div_b_ff <= width_ff;
                     div_start_ff <= 1'b1;
                     state_ff <= S_TX_WAIT;
                  end
               end else begin
                  elapsed_x_ff <= ex_in;
               end
            end
            S_TX_WAIT: begin
               if (div_done) begin
                  offset_x_ff <= div_rem[OFFSET_W-1:0];
                  state_ff <= S_TY;
               end
            end
            S_TY: begin
               state_ff <= S_TDONE;
               if (move_y) begin
                  elapsed_y_ff <= '0;
                  moved_ff <= 1'b1;
                  if (height_ff == '0) begin
                     offset_y_ff <= '0;
                  end else begin
                     div_a_ff <= 13'(offset_y_ff) + 13'd1;
                     div_b_ff <= height_ff;
                     div_start_ff <= 1'b1;
                     state_ff <= S_TY_WAIT;
                  end
               end else begin
                  elapsed_y_ff <= ey_in;
               end
            end
            S_TY_WAIT: begin
               if (div_done) begin
                  offset_y_ff <= div_rem[OFFSET_W-1:0];
                  state_ff <= S_TDONE;
               end
            end
            S_TDONE: begin
               rsp_ff <= pack_rsp(9'd0, 24'd0, pending_ff || moved_ff, bad_ff);
               rsp_valid_ff <= 1'b1;
               pending_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
            S_R0: begin
               if (!cmd_ff.map_ok) begin
                  rsp_ff <= pack_rsp(9'd0, 24'd0, 1'b0, bad_ff);
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  y_ff <= y_calc;
                  state_ff <= S_R_XY_WAIT;
               end
            end
            S_R_XY_WAIT: begin
               led_ff <= map_rdata;
               if (bad_ff) begin
                  rsp_ff <= pack_rsp(map_rdata, 24'd0, 1'b0, 1'b1);
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  div_a_ff <= x_calc + 13'(offset_x_ff);
                  div_b_ff <= width_ff;
                  div_start_ff <= 1'b1;
                  state_ff <= S_R_GX_WAIT;
               end
            end
            S_R_GX_WAIT: begin
               if (div_done) begin
                  gx_ff <= div_rem;
                  div_a_ff <= 13'(y_ff) + 13'(offset_y_ff);
                  div_b_ff <= height_ff;
                  div_start_ff <= 1'b1;
                  state_ff <= S_R_GY_WAIT;
               end
            end
            S_R_GY_WAIT: begin
               if (div_done) begin
                  gy_ff <= div_rem;
                  state_ff <= S_R_IDX;
               end
            end
            S_R_IDX: begin
               idx_ff <= 26'(gy_ff) * 26'(width_ff) + 26'(gx_ff);
               state_ff <= S_R_READ;
            end
            S_R_READ: begin
               state_ff <= S_R_DATA;
            end
            S_R_DATA: begin
               rsp_ff <= pack_rsp(led_ff,
                                  (32'(idx_ff) < 32'(IMAGE_PIXELS)) ? pix_rdata : 24'd0,
                                  1'b0, 1'b0);
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (csr.valid) begin
            pending_ff <= 1'b1;
            unique case (csr.index)
               REG_WIDTH: width_ff <= csr.data;
               REG_HEIGHT: height_ff <= csr.data;
               REG_SPEED_X: begin
                  speed_x_ff <= csr.data[SPEED_W-1:0];
                  if (csr.data[SPEED_W-1:0] == '0) begin
                     offset_x_ff <= '0;
                  end
               end
               default: begin
                  speed_y_ff <= csr.data[SPEED_W-1:0];
                  if (csr.data[SPEED_W-1:0] == '0) begin
                     offset_y_ff <= '0;
                  end
               end
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

// ===== verif/scrolling_led_matrix_remapper_tb.sv =====
// Self-checking testbench of the scrolling LED matrix remapper with a built-in predictor.
`timescale 1ns / 1ps
`default_nettype none
module scrolling_led_matrix_remapper_tb;
   import slmr_pkg::*;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [1:0] csr_index;
   logic [SIZE_W-1:0] csr_data;

   scrolling_led_matrix_remapper i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   localparam int LEDS = 512;
   localparam int PIXELS = 4096;

   // Predicted contents of the block.
   logic [23:0] pixel_mem [PIXELS];
   bit pixel_seen [PIXELS];
   logic [8:0] led_table [LEDS];
   bit led_seen [LEDS];
   int img_w = 2, img_h = 2, spd_x = 0, spd_y = 0;
   int ofs_x = 0, ofs_y = 0, ela_x = 0, ela_y = 0;
   bit redraw_pending = 1;

   req_type word_queue[$];
   rsp_type awaited_rsp[$];
   int mismatches = 0;
   int words_taken = 0;
   int renders_sent = 0;
   int ticks_sent = 0;
   int gap = 0;
   bit quiet = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic bit size_is_bad();
      return img_w == 0 || img_h == 0 || img_w * img_h > PIXELS;
   endfunction

   function automatic bit advance_axis(input int spd, input int sz, inout int ofs, inout int ela);
      if (ela < 2047) ela++;
      if (spd == 0 || ela <= 1000 / spd) return 0;
      ofs = (sz == 0) ? 0 : ((ofs + 1) % sz) & 12'hFFF;
      ela = 0;
      return 1;
   endfunction

   function automatic rsp_type predict_word(input req_type w);
      rsp_type r;
      int gx, gy, idx;
      r = '0;
      r.size_error = size_is_bad();
      case (w.opcode)
         OP_PIXEL: begin
            pixel_mem[w.address] = {w.red_in, w.green_in, w.blue_in};
            pixel_seen[w.address] = 1;
            redraw_pending = 1;
         end
         OP_MAP: begin
            if (w.address < LEDS) begin
               led_table[w.address] = w.led_position;
               led_seen[w.address] = 1;
               redraw_pending = 1;
            end
         end
         OP_TICK: begin
            if (advance_axis(spd_x, img_w, ofs_x, ela_x)) redraw_pending = 1;
            if (advance_axis(spd_y, img_h, ofs_y, ela_y)) redraw_pending = 1;
            r.refresh_due = redraw_pending;
            redraw_pending = 0;
         end
         default: begin
            if (w.address < LEDS) begin
               r.led_index = led_table[w.address];
               if (!size_is_bad()) begin
                  gx = (w.address % 32 + ofs_x) % img_w;
                  gy = (w.address / 32 + ofs_y) % img_h;
                  idx = gy * img_w + gx;
                  {r.red_out, r.green_out, r.blue_out} = pixel_mem[idx];
               end
            end
         end
      endcase
      return r;
   endfunction

   task automatic push_word(input req_type w);
      awaited_rsp.push_back(predict_word(w));
      word_queue.push_back(w);
      if (w.opcode == OP_RENDER) renders_sent++;
      if (w.opcode == OP_TICK) ticks_sent++;
   endtask

   // Renders never read an entry that was not written: the entry is written first.
   task automatic add_word(input req_type w);
      req_type fill;
      int gx, gy, idx;
      if (w.opcode == OP_RENDER && w.address < LEDS) begin
         if (!led_seen[w.address]) begin
            fill = w;
            fill.opcode = OP_MAP;
            fill.led_position = 9'($urandom);
            push_word(fill);
         end
         if (!size_is_bad()) begin
            gx = (w.address % 32 + ofs_x) % img_w;
            gy = (w.address / 32 + ofs_y) % img_h;
            idx = gy * img_w + gx;
            if (!pixel_seen[idx]) begin
               fill = w;
               fill.opcode = OP_PIXEL;
               fill.address = 12'(idx);
               {fill.red_in, fill.green_in, fill.blue_in} = 24'($urandom);
               push_word(fill);
            end
         end
      end
      push_word(w);
   endtask

   function automatic req_type make_word(input logic [1:0] op, input int addr, input int rgb,
                                         input int pos);
      req_type w;
      w.opcode = op;
      w.address = 12'(addr);
      {w.red_in, w.green_in, w.blue_in} = 24'(rgb);
      w.led_position = 9'(pos);
      return w;
   endfunction

   task automatic wait_idle();
      while (word_queue.size() != 0 || start || awaited_rsp.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= 13'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      case (idx)
         REG_WIDTH: img_w = value & 13'h1FFF;
         REG_HEIGHT: img_h = value & 13'h1FFF;
         REG_SPEED_X: begin
            spd_x = value & 10'h3FF;
            if (spd_x == 0) ofs_x = 0;
         end
         default: begin
            spd_y = value & 10'h3FF;
            if (spd_y == 0) ofs_y = 0;
         end
      endcase
      redraw_pending = 1;
   endtask

   task automatic run_phase(input int w, input int h, input int sx, input int sy, input int count,
                            input int tick_pct);
      req_type r;
      int area;
      wait_idle();
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_SPEED_X, sx);
      write_reg(REG_SPEED_Y, sy);
      area = (w * h > 0 && w * h <= PIXELS) ? w * h : PIXELS;
      for (int k = 0; k < count; k++) begin
         r.red_in = 8'($urandom);
         r.green_in = 8'($urandom);
         r.blue_in = 8'($urandom);
         r.led_position = 9'($urandom);
         r.address = 12'($urandom);
         if ($urandom_range(0, 99) < tick_pct) begin
            r.opcode = OP_TICK;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2: begin
                  r.opcode = OP_PIXEL;
                  if ($urandom_range(0, 4) != 0) r.address = 12'($urandom_range(0, area - 1));
               end
               3, 4: begin
                  r.opcode = OP_MAP;
                  if ($urandom_range(0, 5) != 0) r.address = 12'($urandom_range(0, LEDS - 1));
               end
               default: begin
                  r.opcode = OP_RENDER;
                  if ($urandom_range(0, 7) != 0) r.address = 12'($urandom_range(0, LEDS - 1));
               end
            endcase
         end
         add_word(r);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
         req_data <= '0;
         gap = 0;
      end else begin
         if (start && !busy) words_taken++;
         if (!(start && busy)) begin
            if (gap > 0) begin
               gap--;
               start <= 0;
            end else if (word_queue.size() != 0) begin
               if (!quiet && $urandom_range(0, 7) == 0) begin
                  gap = $urandom_range(0, 2);
                  start <= 0;
               end else begin
                  start <= 1;
                  req_data <= word_queue.pop_front();
               end
            end else begin
               start <= 0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (awaited_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result word %p", rsp_data);
         end else begin
            rsp_type e;
            e = awaited_rsp.pop_front();
            if (rsp_data.led_index !== e.led_index || rsp_data.red_out !== e.red_out ||
                rsp_data.green_out !== e.green_out || rsp_data.blue_out !== e.blue_out ||
                rsp_data.refresh_due !== e.refresh_due ||
                rsp_data.size_error !== e.size_error) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %p, got %p", e, rsp_data);
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("Timeout with %0d results outstanding.", awaited_rsp.size());
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      reset = 1;
      csr_valid = 0;
      csr_index = '0;
      csr_data = '0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      add_word(make_word(OP_TICK, 0, 0, 0));
      add_word(make_word(OP_PIXEL, 4095, 24'hFFFFFF, 511));
      add_word(make_word(OP_PIXEL, 0, 0, 0));
      add_word(make_word(OP_PIXEL, 3, 24'hA5C3F0, 0));
      add_word(make_word(OP_MAP, 511, 0, 511));
      add_word(make_word(OP_MAP, 0, 24'hFFFFFF, 0));
      add_word(make_word(OP_MAP, 4095, 0, 511));
      add_word(make_word(OP_MAP, 512, 0, 3));
      add_word(make_word(OP_RENDER, 0, 0, 0));
      add_word(make_word(OP_RENDER, 511, 0, 0));
      add_word(make_word(OP_RENDER, 512, 0, 0));
      add_word(make_word(OP_RENDER, 4095, 24'hFFFFFF, 511));
      add_word(make_word(OP_TICK, 4095, 24'hFFFFFF, 511));
      add_word(make_word(OP_TICK, 0, 0, 0));
      add_word(make_word(OP_RENDER, 33, 0, 0));

      run_phase(2, 2, 0, 0, 60, 15);
      run_phase(64, 64, 1000, 500, 120, 30);
      run_phase(4096, 1, 7, 0, 90, 25);
      run_phase(1, 4096, 0, 3, 90, 25);
      run_phase(0, 8, 10, 10, 50, 40);
      run_phase(65, 64, 20, 20, 50, 40);
      run_phase(32, 16, 0, 0, 200, 95);
      run_phase(32, 16, 1, 1000, 100, 50);
      run_phase(13, 7, 1000, 0, 70, 40);
      wait_idle();
      quiet = 1;
      run_phase(5, 3, 999, 1, 100, 30);
      wait_idle();

      $display("Covered %0d words (%0d renders, %0d ticks) over ten register settings.",
               words_taken, renders_sent, ticks_sent);
      if (mismatches == 0 && awaited_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing.", mismatches, awaited_rsp.size());
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
src/slmr_pkg.sv
src/slmr_ram.sv
src/slmr_div.sv
src/slmr_front.sv
src/slmr_back.sv
src/scrolling_led_matrix_remapper.sv
verif/scrolling_led_matrix_remapper_tb.sv
